### src/dsc_pkg.sv
// Shared definitions for the nearest-neighbour RGB565 downscaler.
// Holds the configuration register indexes, colour masks and the result record.
// No dependencies.
package dsc_pkg;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } cfg_index_t;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [4:0] RED_BLUE_MASK = 5'h1F;
    localparam logic [5:0] GREEN_MASK    = 6'h3F;

    localparam int PIXEL_BITS   = 16;
    localparam int CHANNEL_BITS = 8;

    typedef struct packed {
        logic                    valid;
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic                    row_end;
        logic                    frame_end;
    } result_t;

endpackage

### src/dsc_cfg.sv
// Size registers of the downscaler and the effective sizes derived from them.
// Zero sizes count as one and target sizes are clamped to the source sizes.
// Depends on dsc_pkg.
module dsc_cfg
    import dsc_pkg::*;
#(
    parameter int DIMENSION_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIMENSION_BITS-1:0] cfg_wr_data,
    output logic [DIMENSION_BITS-1:0] eff_src_w,
    output logic [DIMENSION_BITS-1:0] eff_src_h,
    output logic [DIMENSION_BITS-1:0] eff_dst_w,
    output logic [DIMENSION_BITS-1:0] eff_dst_h
);

    localparam logic [DIMENSION_BITS-1:0] ONE = DIMENSION_BITS'(1);

    logic [DIMENSION_BITS-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIMENSION_BITS-1:0] dst_w_raw, dst_h_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= DIMENSION_BITS'(800);
            src_h_reg <= DIMENSION_BITS'(640);
            dst_w_reg <= DIMENSION_BITS'(96);
            dst_h_reg <= DIMENSION_BITS'(96);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_SOURCE_WIDTH:  src_w_reg <= cfg_wr_data;
                REG_SOURCE_HEIGHT: src_h_reg <= cfg_wr_data;
                REG_TARGET_WIDTH:  dst_w_reg <= cfg_wr_data;
                REG_TARGET_HEIGHT: dst_h_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_src_w = (src_w_reg == '0) ? ONE : src_w_reg;
        eff_src_h = (src_h_reg == '0) ? ONE : src_h_reg;
        dst_w_raw = (dst_w_reg == '0) ? ONE : dst_w_reg;
        dst_h_raw = (dst_h_reg == '0) ? ONE : dst_h_reg;
        eff_dst_w = (dst_w_raw > eff_src_w) ? eff_src_w : dst_w_raw;
        eff_dst_h = (dst_h_raw > eff_src_h) ? eff_src_h : dst_h_raw;
    end

endmodule

### src/dsc_scan.sv
// Input register, raster counters and accumulators of the downscaler.
// Decides per source pixel whether it is kept and forms the RGB888 result.
// Depends on dsc_pkg.
module dsc_scan
    import dsc_pkg::*;
#(
    parameter int DIMENSION_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [PIXEL_BITS-1:0]     s_tdata,
    input  logic                      s_tuser,
    input  logic [DIMENSION_BITS-1:0] eff_src_w,
    input  logic [DIMENSION_BITS-1:0] eff_src_h,
    input  logic [DIMENSION_BITS-1:0] eff_dst_w,
    input  logic [DIMENSION_BITS-1:0] eff_dst_h,
    input  logic                      out_take,
    output logic                      fire,
    output result_t                   result
);

    localparam int D = DIMENSION_BITS;
    localparam int A = 2 * DIMENSION_BITS;

    logic                  in_valid_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic                  start_reg;

    logic [D-1:0] sc_reg, sr_reg, tc_reg, tr_reg;
    logic [A-1:0] cta_reg, csa_reg, rta_reg, rsa_reg;
    logic [D-1:0] sc_next, sr_next, tc_next, tr_next;
    logic [A-1:0] cta_next, csa_next, rta_next, rsa_next;

    logic [D-1:0] sc, sr, tc, tr;
    logic [A-1:0] cta, csa, rta, rsa;
    logic [A:0]   row_lim, col_lim;
    logic         row_keep, col_keep, keep;

    function automatic logic [D-1:0] ONE_D();
        return D'(1);
    endfunction

    assign fire     = in_valid_reg && out_take;
    assign s_tready = !in_valid_reg || out_take;

    always_comb begin
        sc  = start_reg ? '0 : sc_reg;
        sr  = start_reg ? '0 : sr_reg;
        tc  = start_reg ? '0 : tc_reg;
        tr  = start_reg ? '0 : tr_reg;
        cta = start_reg ? '0 : cta_reg;
        csa = start_reg ? '0 : csa_reg;
        rta = start_reg ? '0 : rta_reg;
        rsa = start_reg ? '0 : rsa_reg;

        row_lim  = {1'b0, rsa} + (A+1)'(eff_dst_h);
        col_lim  = {1'b0, csa} + (A+1)'(eff_dst_w);
        row_keep = (tr < eff_dst_h) && ({1'b0, rta} < row_lim);
        col_keep = (tc < eff_dst_w) && ({1'b0, cta} < col_lim);
        keep     = row_keep && col_keep;

        result.valid     = keep;
        result.red       = {pix_reg[15:11] & RED_BLUE_MASK, 3'b000};
        result.green     = {pix_reg[10:5] & GREEN_MASK, 2'b00};
        result.blue      = {pix_reg[4:0] & RED_BLUE_MASK, 3'b000};
        result.row_end   = (tc == eff_dst_w - ONE_D());
        result.frame_end = result.row_end && (tr == eff_dst_h - ONE_D());

        sc_next  = sc;
        sr_next  = sr;
        tc_next  = tc;
        tr_next  = tr;
        cta_next = cta;
        csa_next = csa;
        rta_next = rta;
        rsa_next = rsa;

        if (keep) begin
            tc_next  = tc + ONE_D();
            cta_next = cta + A'(eff_src_w);
        end

        if (sc >= eff_src_w - ONE_D()) begin
            sc_next  = '0;
            tc_next  = '0;
            cta_next = '0;
            csa_next = '0;
            if (row_keep) begin
                tr_next  = tr + ONE_D();
                rta_next = rta + A'(eff_src_h);
            end
            if (sr >= eff_src_h - ONE_D()) begin
                sr_next  = '0;
                tr_next  = '0;
                rta_next = '0;
                rsa_next = '0;
            end else begin
                sr_next  = sr + ONE_D();
                rsa_next = rsa + A'(eff_dst_h);
            end
        end else begin
            sc_next  = sc + ONE_D();
            csa_next = csa + A'(eff_dst_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sc_reg  <= '0;
            sr_reg  <= '0;
            tc_reg  <= '0;
            tr_reg  <= '0;
            cta_reg <= '0;
            csa_reg <= '0;
            rta_reg <= '0;
            rsa_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                sc_reg  <= sc_next;
                sr_reg  <= sr_next;
                tc_reg  <= tc_next;
                tr_reg  <= tr_next;
                cta_reg <= cta_next;
                csa_reg <= csa_next;
                rta_reg <= rta_next;
                rsa_reg <= rsa_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pix_reg   <= s_tdata;
            start_reg <= s_tuser;
        end
    end

endmodule

### src/dsc_out.sv
// Result register of the downscaler, driving the master-side stream.
// Takes a new result whenever it is empty or its request is being taken.
// Depends on dsc_pkg.
module dsc_out
    import dsc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  result_t                   result,
    output logic                      out_take,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [3*CHANNEL_BITS-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);

    logic                      valid_reg;
    logic [3*CHANNEL_BITS-1:0] data_reg;
    logic                      last_reg;
    logic                      user_reg;

    assign out_take = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_take) begin
            valid_reg <= fire && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            data_reg <= {result.blue, result.green, result.red};
            last_reg <= result.row_end;
            user_reg <= result.frame_end;
        end
    end

endmodule

### src/nearest_neighbor_downscale_rgb565.sv
// Top level of the nearest-neighbour RGB565 to RGB888 downscaler.
// Instantiates dsc_cfg, dsc_scan and dsc_out; depends on dsc_pkg.
//
// Channel  Direction  Payload
// s_       in         tdata = pixel_rgb565, tuser = frame_start
// m_       out        tdata = red, green, blue; tlast = row_end; tuser = frame_end
// cfg_     in         write enable, register index 0..3, size value
//
// One source pixel is taken per clock cycle while s_tready is high; a kept pixel passes
// through the input register and then the result register to the master side.
// Reset is synchronous and active low and clears all counters and accumulators.
// While a result waits on the master side both registers hold, and s_tready falls
// once the input register is also full.
module nearest_neighbor_downscale_rgb565
    import dsc_pkg::*;
#(
    parameter int DIMENSION_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [PIXEL_BITS-1:0]     s_tdata,  // pixel_rgb565
    input  logic                      s_tuser,  // frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [3*CHANNEL_BITS-1:0] m_tdata,  // red, green, blue
    output logic                      m_tlast,
    output logic                      m_tuser,  // frame_end
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIMENSION_BITS-1:0] cfg_wr_data
);

    logic [DIMENSION_BITS-1:0] eff_src_w, eff_src_h, eff_dst_w, eff_dst_h;
    logic                      out_take;
    logic                      fire;
    result_t                   result;

    dsc_cfg #(
        .DIMENSION_BITS(DIMENSION_BITS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .eff_src_w  (eff_src_w),
        .eff_src_h  (eff_src_h),
        .eff_dst_w  (eff_dst_w),
        .eff_dst_h  (eff_dst_h)
    );

    dsc_scan #(
        .DIMENSION_BITS(DIMENSION_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .eff_src_w(eff_src_w),
        .eff_src_h(eff_src_h),
        .eff_dst_w(eff_dst_w),
        .eff_dst_h(eff_dst_h),
        .out_take (out_take),
        .fire     (fire),
        .result   (result)
    );

    dsc_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .result  (result),
        .out_take(out_take),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_downscale_rgb565.
// Drives RGB565 requests against a cycle-free predictor of the kept pixels and
// checks every RGB888 output; depends on dsc_pkg and the downscaler RTL.
module testbench
    import dsc_pkg::*;
();

    localparam int DIM_BITS    = 12;
    localparam int ACC_BITS    = 2 * DIM_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_MODE = 120;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } rgb888_t;

    typedef struct {
        int          setting;
        logic [15:0] pixel;
        logic        start;
        bit          typed;
        rgb888_t     px;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = REG_SOURCE_WIDTH;
    logic [DIM_BITS-1:0]   cfg_wr_data = '0;

    // Register copy and scan state of the predictor.
    logic [DIM_BITS-1:0] cfg_src_w = 12'd800;
    logic [DIM_BITS-1:0] cfg_src_h = 12'd640;
    logic [DIM_BITS-1:0] cfg_dst_w = 12'd96;
    logic [DIM_BITS-1:0] cfg_dst_h = 12'd96;
    logic [DIM_BITS-1:0] src_x = '0, src_y = '0, dst_x = '0, dst_y = '0;
    logic [ACC_BITS-1:0] x_dst_sum = '0, x_src_sum = '0, y_dst_sum = '0, y_src_sum = '0;

    rgb888_t pending_pixels [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 25;
    int      recv_idle_pct = 48;

    logic [DIM_BITS-1:0] directed_sizes [4][4] = '{
        '{12'd2, 12'd2, 12'd2, 12'd2},
        '{12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd3, 12'd3, 12'd5, 12'd5},
        '{12'd4, 12'd2, 12'd2, 12'd1}
    };
    stim_row_t directed_rows [24];

    nearest_neighbor_downscale_rgb565 #(
        .DIMENSION_BITS(DIM_BITS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Returns 1 when the pixel is kept, and the widened pixel with its flags.
    function automatic bit downscale_pixel(input logic [15:0] pix, input logic start,
                                           output rgb888_t px);
        logic [DIM_BITS-1:0] sw, sh, dw, dh;
        bit row_keep, col_keep;
        sw = (cfg_src_w == 0) ? 12'd1 : cfg_src_w;
        sh = (cfg_src_h == 0) ? 12'd1 : cfg_src_h;
        dw = (cfg_dst_w == 0) ? 12'd1 : cfg_dst_w;
        dh = (cfg_dst_h == 0) ? 12'd1 : cfg_dst_h;
        if (dw > sw) dw = sw;
        if (dh > sh) dh = sh;
        px = '0;
        if (start) begin
            {src_x, dst_x, x_dst_sum, x_src_sum} = '0;
            {src_y, dst_y, y_dst_sum, y_src_sum} = '0;
        end
        // The sums are compared one bit wider so that the addition cannot wrap.
        row_keep = (dst_y < dh) &&
                   ((ACC_BITS+1)'(y_dst_sum) < (ACC_BITS+1)'(y_src_sum) + (ACC_BITS+1)'(dh));
        col_keep = (dst_x < dw) &&
                   ((ACC_BITS+1)'(x_dst_sum) < (ACC_BITS+1)'(x_src_sum) + (ACC_BITS+1)'(dw));
        if (row_keep && col_keep) begin
            px.red       = {pix[15:11], 3'b000};
            px.green     = {pix[10:5], 2'b00};
            px.blue      = {pix[4:0], 3'b000};
            px.row_end   = (dst_x == dw - 1'b1);
            px.frame_end = px.row_end && (dst_y == dh - 1'b1);
            dst_x     = dst_x + 1'b1;
            x_dst_sum = x_dst_sum + ACC_BITS'(sw);
        end
        if (src_x >= sw - 1'b1) begin
            {src_x, dst_x, x_dst_sum, x_src_sum} = '0;
            if (row_keep) begin
                dst_y     = dst_y + 1'b1;
                y_dst_sum = y_dst_sum + ACC_BITS'(sh);
            end
            if (src_y >= sh - 1'b1) begin
                {src_y, dst_y, y_dst_sum, y_src_sum} = '0;
            end else begin
                src_y     = src_y + 1'b1;
                y_src_sum = y_src_sum + ACC_BITS'(dh);
            end
        end else begin
            src_x     = src_x + 1'b1;
            x_src_sum = x_src_sum + ACC_BITS'(dw);
        end
        return row_keep && col_keep;
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input logic start,
                              input bit typed, input rgb888_t typed_px);
        rgb888_t px;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        if (downscale_pixel(pix, start, px)) begin
            pending_pixels.push_back(typed ? typed_px : px);
        end
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // A request that keeps no pixel may still be in flight after the last result.
    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sizes(input logic [DIM_BITS-1:0] sw, input logic [DIM_BITS-1:0] sh,
                               input logic [DIM_BITS-1:0] dw, input logic [DIM_BITS-1:0] dh);
        logic [DIM_BITS-1:0] vals [4];
        vals = '{sw, sh, dw, dh};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_index_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            case (cfg_index_t'(i))
                REG_SOURCE_WIDTH:  cfg_src_w = vals[i];
                REG_SOURCE_HEIGHT: cfg_src_h = vals[i];
                REG_TARGET_WIDTH:  cfg_dst_w = vals[i];
                REG_TARGET_HEIGHT: cfg_dst_h = vals[i];
            endcase
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h %b %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end else begin
                check_field("red", pending_pixels[0].red, m_tdata[7:0]);
                check_field("green", pending_pixels[0].green, m_tdata[15:8]);
                check_field("blue", pending_pixels[0].blue, m_tdata[23:16]);
                check_field("row_end", 8'(pending_pixels[0].row_end), 8'(m_tlast));
                check_field("frame_end", 8'(pending_pixels[0].frame_end), 8'(m_tuser));
                void'(pending_pixels.pop_front());
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int phase;
        int sent;
        int frames;
        int frame_len;
        int cut;
        bit pause;
        logic start;
        logic [DIM_BITS-1:0] sw, sh, dw, dh;

        directed_rows = '{
            // Reset sizes: the first pixel of a frame is always kept.
            '{-1, 16'hFFFF, 1'b1, 1'b1, '{8'hF8, 8'hFC, 8'hF8, 1'b0, 1'b0}},
            '{-1, 16'h1234, 1'b0, 1'b0, '0},
            // Two by two to two by two keeps every pixel.
            '{0, 16'hFFFF, 1'b1, 1'b1, '{8'hF8, 8'hFC, 8'hF8, 1'b0, 1'b0}},
            '{-1, 16'h0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
            '{-1, 16'hF800, 1'b0, 1'b1, '{8'hF8, 8'h00, 8'h00, 1'b0, 1'b0}},
            '{-1, 16'h07E0, 1'b0, 1'b1, '{8'h00, 8'hFC, 8'h00, 1'b1, 1'b1}},
            // The frame wraps without a frame-start flag, then a flag resynchronises.
            '{-1, 16'h001F, 1'b0, 1'b1, '{8'h00, 8'h00, 8'hF8, 1'b0, 1'b0}},
            '{-1, 16'hAAAA, 1'b1, 1'b0, '0},
            // Zero sizes behave as one by one.
            '{1, 16'hFFFF, 1'b1, 1'b1, '{8'hF8, 8'hFC, 8'hF8, 1'b1, 1'b1}},
            '{-1, 16'h0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
            // A larger target is clamped to the source size.
            '{2, 16'h5555, 1'b1, 1'b0, '0},
            '{-1, 16'h8421, 1'b0, 1'b0, '0},
            '{-1, 16'h7BEF, 1'b0, 1'b0, '0},
            '{-1, 16'hC631, 1'b0, 1'b0, '0},
            '{-1, 16'h39E7, 1'b0, 1'b0, '0},
            '{-1, 16'hFFFF, 1'b0, 1'b0, '0},
            '{-1, 16'h0001, 1'b0, 1'b0, '0},
            '{-1, 16'h8000, 1'b0, 1'b0, '0},
            '{-1, 16'h0020, 1'b0, 1'b0, '0},
            // Four by two to two by one: the second row finds every target done.
            '{3, 16'h1111, 1'b1, 1'b0, '0},
            '{-1, 16'h2222, 1'b0, 1'b0, '0},
            '{-1, 16'h3333, 1'b0, 1'b0, '0},
            '{-1, 16'h4444, 1'b0, 1'b0, '0},
            '{-1, 16'h5555, 1'b0, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].setting >= 0) begin
                settle_block();
                write_sizes(directed_sizes[directed_rows[r].setting][0],
                            directed_sizes[directed_rows[r].setting][1],
                            directed_sizes[directed_rows[r].setting][2],
                            directed_sizes[directed_rows[r].setting][3]);
            end
            send_pixel(directed_rows[r].pixel, directed_rows[r].start,
                       directed_rows[r].typed, directed_rows[r].px);
        end

        // The last directed frame is left open, so the first new sizes apply mid-frame.
        phase = 0;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 48 : 0;
            recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 25 : 0;
            sent = 0;
            while (sent < ITEMS_PER_MODE) begin
                if (phase % 5 == 2) begin
                    case ((phase / 5) % 4)
                        0: {sw, sh, dw, dh} = {12'd4095, 12'd4095, 12'd4095, 12'd4095};
                        1: {sw, sh, dw, dh} = {12'd4095, 12'd1, 12'd1, 12'd4095};
                        2: {sw, sh, dw, dh} = {12'd1, 12'd4095, 12'd0, 12'd4095};
                        default: {sw, sh, dw, dh} = {12'd4095, 12'd4095, 12'd1, 12'd1};
                    endcase
                end else begin
                    sw = 12'($urandom_range(0, 14));
                    sh = 12'($urandom_range(0, 8));
                    dw = 12'($urandom_range(0, sw + 3));
                    dh = 12'($urandom_range(0, sh + 3));
                end
                settle_block();
                write_sizes(sw, sh, dw, dh);
                frame_len = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
                frames = $urandom_range(1, 3);
                if (frame_len > 64) begin
                    frame_len = 40;
                    frames = 1;
                end
                pause = (phase % 4 == 1);
                for (int f = 0; f < frames; f++) begin
                    // Now and then a frame is cut short and the next one starts early.
                    cut = ($urandom_range(9) == 0) ? $urandom_range(1, frame_len) : frame_len;
                    for (int i = 0; i < cut; i++) begin
                        if (pause && i == frame_len / 2) begin
                            wait_for_results();
                            pause = 1'b0;
                        end
                        start = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(39) == 0);
                        send_pixel(16'($urandom_range(16'hFFFF)), start, 1'b0, '0);
                        sent++;
                    end
                end
                phase++;
            end
        end

        settle_block();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
